// ----- rtl/core/spectral_peak_top_k_unit_assert.svh -----
// assertion macros for the spectral peak top-k unit
`ifndef SPECTRAL_PEAK_TOP_K_UNIT_ASSERT_SVH
`define SPECTRAL_PEAK_TOP_K_UNIT_ASSERT_SVH

// same-cycle implication
`define SPT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spt assertion failed");

// next-cycle implication
`define SPT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spt assertion failed");

`endif

// ----- rtl/core/spt_pkg.sv -----
// shared types and constants of the spectral peak top-k unit
package spt_pkg;

    localparam int TOP_K       = 8;
    localparam int MAX_SAMPLES = 4096;
    localparam int AMP_W       = 24;
    localparam int BIN_W       = 11;
    localparam int RANK_W      = 3;
    localparam int CNT_W       = $clog2(TOP_K + 1);
    localparam int TOP_BIN     = MAX_SAMPLES / 2 - 1;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    typedef enum logic [1:0] {
        REG_MIN_AMP   = 2'd0,
        REG_START_BIN = 2'd1,
        REG_STOP_BIN  = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [AMP_W-1:0] min_amp;
        logic [BIN_W-1:0] start_bin;
        logic [BIN_W-1:0] stop_bin;
    } t_cfg;

    typedef struct packed {
        logic [AMP_W-1:0] amp;
        logic [BIN_W-1:0] bin;
    } t_entry;

    typedef struct packed {
        logic ins;
        logic shift;
    } t_cell_cmd;

endpackage

// ----- rtl/core/spt_cell.sv -----
// one slot of the sorted peak list, inserts from above and shifts up on readout
module spt_cell (
    input  logic                i_clk,
    input  spt_pkg::t_cell_cmd  i_cmd,
    input  logic                i_occ,
    input  spt_pkg::t_entry     i_new,
    input  spt_pkg::t_entry     i_above,
    input  logic                i_above_cmp,
    input  spt_pkg::t_entry     i_below,
    output spt_pkg::t_entry     o_entry,
    output logic                o_cmp
);

    spt_pkg::t_entry r_entry;
    spt_pkg::t_entry n_entry;

    assign o_cmp   = !i_occ || (i_new.amp > r_entry.amp);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.shift) begin
            n_entry = i_below;
        end else if (i_cmd.ins && i_above_cmp) begin
            n_entry = i_above;
        end else if (i_cmd.ins && o_cmp) begin
            n_entry = i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ----- rtl/core/spt_cfg.sv -----
// apb register block of the spectral peak top-k unit
module spt_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [spt_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [spt_pkg::APB_DATA_W-1:0] pwdata,
    output logic [spt_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output spt_pkg::t_cfg                  o_cfg
);

    spt_pkg::t_cfg    r_cfg;
    spt_pkg::t_reg_idx w_idx;

    assign pready = 1'b1;
    assign o_cfg  = r_cfg;
    assign w_idx  = spt_pkg::t_reg_idx'(paddr[3:2]);

    always_comb begin
        unique case (w_idx)
            spt_pkg::REG_MIN_AMP:   prdata = spt_pkg::APB_DATA_W'(r_cfg.min_amp);
            spt_pkg::REG_START_BIN: prdata = spt_pkg::APB_DATA_W'(r_cfg.start_bin);
            spt_pkg::REG_STOP_BIN:  prdata = spt_pkg::APB_DATA_W'(r_cfg.stop_bin);
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_amp   <= '0;
            r_cfg.start_bin <= spt_pkg::BIN_W'(1);
            r_cfg.stop_bin  <= spt_pkg::BIN_W'(2047);
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_idx)
                spt_pkg::REG_MIN_AMP:   r_cfg.min_amp   <= pwdata[spt_pkg::AMP_W-1:0];
                spt_pkg::REG_START_BIN: r_cfg.start_bin <= pwdata[spt_pkg::BIN_W-1:0];
                spt_pkg::REG_STOP_BIN:  r_cfg.stop_bin  <= pwdata[spt_pkg::BIN_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ----- rtl/core/spectral_peak_top_k_unit.sv -----
// spectral peak top-k unit: peak detection and a chain of sorted list cells
//
// Takes one spectrum bin per word and keeps the TOP_K largest peaks of the
// frame in a row of cells sorted by descending amplitude. A bin word that
// itself passes as a peak that must be decided at once (it sits on the last
// searched bin or carries frame end) gets its own insertion in the S_SECOND
// state, after that of any held peak; no bin word is taken in that state.
// Each cell compares against the new entry in parallel. After the frame-end
// word the list is read out from the head cell, one entry per cycle while the
// output is taken, max(1, peak count) words in all; no bin word is accepted
// during readout. Output tdata is driven straight from the head cell, the
// rank counter and the peak count, which hold while the output stalls.
module spectral_peak_top_k_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [10:0] bin_number, [34:11] amplitude, zero fill above
    input  logic [spt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [2:0] rank, [13:3] peak_bin, [37:14] peak_amplitude, [41:38] peak_count
    output logic [spt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] entry_valid
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [spt_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [spt_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [spt_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    typedef enum logic [1:0] {
        S_RUN,
        S_SECOND,
        S_EMIT
    } t_state;

    spt_pkg::t_cfg w_cfg;

    t_state                       r_state, n_state;
    logic [spt_pkg::CNT_W-1:0]    r_count, n_count;
    logic [spt_pkg::RANK_W-1:0]   r_rank, n_rank;
    logic [spt_pkg::AMP_W-1:0]    r_prev_amp, n_prev_amp;
    logic                         r_prev_present, n_prev_present;
    spt_pkg::t_entry              r_held, n_held;
    logic                         r_held_valid, n_held_valid;
    spt_pkg::t_entry              r_pend, n_pend;
    logic                         r_fend, n_fend;

    logic [spt_pkg::BIN_W-1:0]    w_in_bin;
    logic [spt_pkg::AMP_W-1:0]    w_in_amp;
    logic [spt_pkg::BIN_W-1:0]    w_top_bin;
    logic [spt_pkg::BIN_W-1:0]    w_lo_bin;
    logic                         w_in_range;
    logic                         w_pass;
    logic                         w_in_acc;
    logic                         w_out_acc;
    logic                         w_last;
    logic                         w_ins;
    spt_pkg::t_entry              w_ins_entry;
    spt_pkg::t_cell_cmd           w_cmd;

    spt_pkg::t_entry              w_cell_q [spt_pkg::TOP_K];
    logic                         w_cell_cmp [spt_pkg::TOP_K];

    spt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    genvar gi;
    generate
        for (gi = 0; gi < spt_pkg::TOP_K; gi++) begin : g_cell
            spt_pkg::t_entry w_above;
            spt_pkg::t_entry w_below;
            logic            w_above_cmp;
            logic            w_occ;

            if (gi == 0) begin : g_head
                assign w_above     = w_ins_entry;
                assign w_above_cmp = 1'b0;
            end else begin : g_mid
                assign w_above     = w_cell_q[gi-1];
                assign w_above_cmp = w_cell_cmp[gi-1];
            end

            if (gi == spt_pkg::TOP_K - 1) begin : g_tail
                assign w_below = '0;
            end else begin : g_inner
                assign w_below = w_cell_q[gi+1];
            end

            assign w_occ = (r_count > spt_pkg::CNT_W'(gi));

            spt_cell u_cell (
                .i_clk       (i_clk),
                .i_cmd       (w_cmd),
                .i_occ       (w_occ),
                .i_new       (w_ins_entry),
                .i_above     (w_above),
                .i_above_cmp (w_above_cmp),
                .i_below     (w_below),
                .o_entry     (w_cell_q[gi]),
                .o_cmp       (w_cell_cmp[gi])
            );
        end
    endgenerate

    assign w_in_bin  = s_axis_tdata[spt_pkg::BIN_W-1:0];
    assign w_in_amp  = s_axis_tdata[spt_pkg::BIN_W +: spt_pkg::AMP_W];
    assign w_top_bin = (32'(w_cfg.stop_bin) > 32'(spt_pkg::TOP_BIN)) ?
                       spt_pkg::BIN_W'(spt_pkg::TOP_BIN) : w_cfg.stop_bin;
    assign w_lo_bin  = (w_cfg.start_bin == '0) ? spt_pkg::BIN_W'(1) : w_cfg.start_bin;
    assign w_in_range = (w_lo_bin <= w_top_bin) && (w_in_bin >= w_lo_bin) &&
                        (w_in_bin <= w_top_bin);
    assign w_pass    = (w_in_amp >= w_cfg.min_amp) &&
                       (!r_prev_present || (w_in_amp >= r_prev_amp));

    assign s_axis_tready = (r_state == S_RUN);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = (r_state == S_EMIT);
    assign w_out_acc     = m_axis_tvalid && m_axis_tready;
    assign w_last        = (r_count == '0) ||
                           ((spt_pkg::CNT_W'(r_rank) + spt_pkg::CNT_W'(1)) == r_count);

    assign m_axis_tuser  = (r_count != '0);
    assign m_axis_tlast  = w_last;
    assign m_axis_tdata  = spt_pkg::OUT_TDATA_W'({
                               r_count,
                               (r_count != '0) ? w_cell_q[0].amp : spt_pkg::AMP_W'(0),
                               (r_count != '0) ? w_cell_q[0].bin : spt_pkg::BIN_W'(0),
                               r_rank});

    assign w_cmd.ins   = w_ins;
    assign w_cmd.shift = w_out_acc && !w_last;

    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_rank         = r_rank;
        n_prev_amp     = r_prev_amp;
        n_prev_present = r_prev_present;
        n_held         = r_held;
        n_held_valid   = r_held_valid;
        n_pend         = r_pend;
        n_fend         = r_fend;
        w_ins          = 1'b0;
        w_ins_entry    = r_held;

        unique case (r_state)
            S_RUN: begin
                if (w_in_acc) begin
                    n_fend = s_axis_tlast;
                    n_pend = '{amp: w_in_amp, bin: w_in_bin};
                    if (w_in_range) begin
                        w_ins          = r_held_valid && (r_held.amp >= w_in_amp);
                        n_held         = '{amp: w_in_amp, bin: w_in_bin};
                        n_held_valid   = w_pass && (w_in_bin != w_top_bin) && !s_axis_tlast;
                        n_prev_amp     = w_in_amp;
                        n_prev_present = 1'b1;
                    end else begin
                        w_ins = r_held_valid && s_axis_tlast;
                    end
                    if (s_axis_tlast) begin
                        n_held_valid   = 1'b0;
                        n_prev_present = 1'b0;
                        n_prev_amp     = '0;
                    end
                    if (w_in_range && w_pass && ((w_in_bin == w_top_bin) || s_axis_tlast)) begin
                        n_state = S_SECOND;
                    end else if (s_axis_tlast) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_SECOND: begin
                w_ins       = 1'b1;
                w_ins_entry = r_pend;
                n_state     = r_fend ? S_EMIT : S_RUN;
            end
            S_EMIT: begin
                if (w_out_acc) begin
                    if (w_last) begin
                        n_count = '0;
                        n_rank  = '0;
                        n_state = S_RUN;
                    end else begin
                        n_rank = r_rank + spt_pkg::RANK_W'(1);
                    end
                end
            end
            default: n_state = S_RUN;
        endcase

        if (w_ins && (r_count < spt_pkg::CNT_W'(spt_pkg::TOP_K))) begin
            n_count = r_count + spt_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_RUN;
            r_count        <= '0;
            r_rank         <= '0;
            r_prev_amp     <= '0;
            r_prev_present <= 1'b0;
            r_held_valid   <= 1'b0;
            r_fend         <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_count        <= n_count;
            r_rank         <= n_rank;
            r_prev_amp     <= n_prev_amp;
            r_prev_present <= n_prev_present;
            r_held_valid   <= n_held_valid;
            r_fend         <= n_fend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
        r_pend <= n_pend;
    end

`include "spectral_peak_top_k_unit_assert.svh"

    `SPT_ASSERT_NOW(a_count_bound, 1'b1, r_count <= spt_pkg::CNT_W'(spt_pkg::TOP_K))
    `SPT_ASSERT_NOW(a_no_input_in_readout, m_axis_tvalid, !s_axis_tready)
    `SPT_ASSERT_NOW(a_no_held_in_readout, r_state == S_EMIT, !r_held_valid && !r_prev_present)
    `SPT_ASSERT_NEXT(a_list_cleared, w_out_acc && m_axis_tlast, r_count == '0 && s_axis_tready)

endmodule

// ----- bench/tb_spectral_peak_top_k_unit.sv -----
// testbench for spectral_peak_top_k_unit: directed and random frames checked word by word
`timescale 1ns / 100ps

module tb_spectral_peak_top_k_unit;

    localparam int CYCLE_LIMIT   = 100000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_ITEMS  = 190;

    typedef struct packed {
        logic [spt_pkg::RANK_W-1:0] rank;
        logic [spt_pkg::BIN_W-1:0]  peak_bin;
        logic [spt_pkg::AMP_W-1:0]  peak_amp;
        logic                       entry_valid;
        logic [3:0]                 peak_count;
        logic                       last_entry;
    } t_peak_word;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [spt_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                            s_axis_tlast = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [spt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tuser;
    logic                            m_axis_tlast;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [spt_pkg::APB_ADDR_W-1:0]  paddr = '0;
    logic [spt_pkg::APB_DATA_W-1:0]  pwdata = '0;
    logic [spt_pkg::APB_DATA_W-1:0]  prdata;
    logic                            pready;

    // block configuration as the predictor sees it
    logic [spt_pkg::AMP_W-1:0] thr_amp;
    logic [spt_pkg::BIN_W-1:0] lo_bin;
    logic [spt_pkg::BIN_W-1:0] hi_bin;

    // predictor frame state
    logic [spt_pkg::AMP_W-1:0] top_amp [spt_pkg::TOP_K];
    logic [spt_pkg::BIN_W-1:0] top_bin [spt_pkg::TOP_K];
    int                        top_cnt;
    logic [spt_pkg::AMP_W-1:0] prev_amp;
    logic                      prev_seen;
    logic [spt_pkg::AMP_W-1:0] cand_amp;
    logic [spt_pkg::BIN_W-1:0] cand_bin;
    logic                      cand_live;

    t_peak_word  peak_words [$];
    bit          gaps_on = 1'b1;
    int unsigned fail_cnt = 0;
    int unsigned cycle_cnt = 0;
    int          items_sent = 0;

    spectral_peak_top_k_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever begin
            #1 i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("** spectral_peak_top_k_unit: FAILED **");
            $finish;
        end
    end

    function automatic void clear_peaks();
        top_cnt   = 0;
        prev_amp  = '0;
        prev_seen = 1'b0;
        cand_amp  = '0;
        cand_bin  = '0;
        cand_live = 1'b0;
    endfunction

    function automatic void insert_peak(input logic [spt_pkg::BIN_W-1:0] b,
                                        input logic [spt_pkg::AMP_W-1:0] a);
        int pos;
        pos = top_cnt;
        if (pos < spt_pkg::TOP_K) begin
            top_cnt++;
        end else if (a <= top_amp[spt_pkg::TOP_K-1]) begin
            return;
        end else begin
            pos = spt_pkg::TOP_K - 1;
        end
        while (pos > 0 && a > top_amp[pos-1]) begin
            top_amp[pos] = top_amp[pos-1];
            top_bin[pos] = top_bin[pos-1];
            pos--;
        end
        top_amp[pos] = a;
        top_bin[pos] = b;
    endfunction

    function automatic void predict_bin(input logic [spt_pkg::BIN_W-1:0] b,
                                        input logic [spt_pkg::AMP_W-1:0] a,
                                        input logic fe);
        logic [spt_pkg::BIN_W-1:0] lo;
        logic [spt_pkg::BIN_W-1:0] hi;
        logic                      pass;
        t_peak_word                w;
        lo = (lo_bin < 1) ? spt_pkg::BIN_W'(1) : lo_bin;
        hi = (hi_bin > spt_pkg::TOP_BIN) ? spt_pkg::BIN_W'(spt_pkg::TOP_BIN) : hi_bin;
        if (lo <= hi && b >= lo && b <= hi) begin
            if (cand_live) begin
                if (cand_amp >= a) insert_peak(cand_bin, cand_amp);
                cand_live = 1'b0;
            end
            pass = (a >= thr_amp) && (!prev_seen || a >= prev_amp);
            if (pass) begin
                if (b == hi) begin
                    insert_peak(b, a);
                end else begin
                    cand_live = 1'b1;
                    cand_bin  = b;
                    cand_amp  = a;
                end
            end
            prev_amp  = a;
            prev_seen = 1'b1;
        end
        if (fe) begin
            if (cand_live) insert_peak(cand_bin, cand_amp);
            cand_live = 1'b0;
            if (top_cnt == 0) begin
                w = '0;
                w.last_entry = 1'b1;
                peak_words.push_back(w);
            end else begin
                for (int i = 0; i < top_cnt; i++) begin
                    w.rank        = spt_pkg::RANK_W'(i);
                    w.peak_bin    = top_bin[i];
                    w.peak_amp    = top_amp[i];
                    w.entry_valid = 1'b1;
                    w.peak_count  = 4'(top_cnt);
                    w.last_entry  = (i + 1 == top_cnt);
                    peak_words.push_back(w);
                end
            end
            clear_peaks();
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_cnt++;
        end
    endfunction

    always @(negedge i_clk) begin
        m_axis_tready <= !(gaps_on && $urandom_range(0, 99) < 18);
    end

    always @(posedge i_clk) begin
        t_peak_word w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (peak_words.size() == 0) begin
                $error("unexpected result word 0x%0h", m_axis_tdata);
                fail_cnt++;
            end else begin
                w = peak_words.pop_front();
                check_field("rank", w.rank, m_axis_tdata[2:0]);
                check_field("peak_bin", w.peak_bin, m_axis_tdata[13:3]);
                check_field("peak_amplitude", w.peak_amp, m_axis_tdata[37:14]);
                check_field("peak_count", w.peak_count, m_axis_tdata[41:38]);
                check_field("entry_valid", w.entry_valid, m_axis_tuser);
                check_field("last_entry", w.last_entry, m_axis_tlast);
            end
        end
    end

    task automatic send_bin(input logic [spt_pkg::BIN_W-1:0] b,
                            input logic [spt_pkg::AMP_W-1:0] a, input logic fe);
        @(negedge i_clk);
        while (gaps_on && $urandom_range(0, 99) < 18) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, a, b};
        s_axis_tlast  <= fe;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_bin(b, a, fe);
        items_sent++;
    endtask

    task automatic wait_list_out();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        while (peak_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input spt_pkg::t_reg_idx idx, input logic [31:0] val);
        logic [31:0] mask;
        mask = (idx == spt_pkg::REG_MIN_AMP) ? 32'h00FF_FFFF : 32'h0000_07FF;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            spt_pkg::REG_MIN_AMP:   thr_amp = val[spt_pkg::AMP_W-1:0];
            spt_pkg::REG_START_BIN: lo_bin  = val[spt_pkg::BIN_W-1:0];
            spt_pkg::REG_STOP_BIN:  hi_bin  = val[spt_pkg::BIN_W-1:0];
            default: ;
        endcase
        // read back the same register
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("prdata", val & mask, prdata & mask);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_config(input logic [spt_pkg::AMP_W-1:0] thr,
                                input logic [spt_pkg::BIN_W-1:0] lo,
                                input logic [spt_pkg::BIN_W-1:0] hi);
        write_reg(spt_pkg::REG_MIN_AMP, 32'(thr));
        write_reg(spt_pkg::REG_START_BIN, 32'(lo));
        write_reg(spt_pkg::REG_STOP_BIN, 32'(hi));
    endtask

    // out-of-range bin alone gives the empty-frame word
    task automatic test_empty_frame();
        send_bin(11'd0, 24'hFF_FFFF, 1'b1);
        wait_list_out();
    endtask

    // plateau ties and a peak on the last searched bin deciding two entries
    task automatic test_ties_at_range_end();
        send_bin(11'd2044, 24'd5, 1'b0);
        send_bin(11'd2045, 24'd60, 1'b0);
        send_bin(11'd2046, 24'd60, 1'b0);
        send_bin(11'd2047, 24'd60, 1'b1);
        wait_list_out();
    endtask

    // more peaks than list entries, last candidate closed by frame end
    task automatic test_list_overflow();
        logic [spt_pkg::AMP_W-1:0] amps [11];
        amps = '{24'd100, 24'd100, 24'd100, 24'd100, 24'd200, 24'd200, 24'd200,
                 24'd200, 24'd200, 24'd150, 24'd150};
        for (int i = 0; i < 11; i++) send_bin(spt_pkg::BIN_W'(i + 1), amps[i], i == 10);
        wait_list_out();
    endtask

    task automatic test_config_extremes();
        write_config(24'd0, 11'd300, 11'd200);
        send_bin(11'd250, 24'd500, 1'b0);
        send_bin(11'd251, 24'd100, 1'b1);
        wait_list_out();
        write_config(24'hFF_FFFF, 11'd1, 11'd2047);
        send_bin(11'd5, 24'hFF_FFFF, 1'b0);
        send_bin(11'd6, 24'hFF_FFFE, 1'b1);
        wait_list_out();
        write_config(24'd0, 11'd2047, 11'd2047);
        send_bin(11'd2047, 24'd0, 1'b1);
        wait_list_out();
        write_config(24'd0, 11'd1, 11'd1);
        send_bin(11'd1, 24'd7, 1'b1);
        wait_list_out();
    endtask

    task automatic random_config();
        int lo;
        int hi;
        int thr;
        thr = ($urandom_range(0, 3) == 0) ? 0 : ($urandom_range(0, 24'hFF_FFFF)
              >> $urandom_range(0, 16));
        lo = $urandom_range(1, 1800);
        hi = lo + $urandom_range(0, 220);
        if (hi > 2047) hi = 2047;
        case ($urandom_range(0, 7))
            0: begin
                lo = 1;
                hi = 2047;
            end
            1: if (lo > 1) hi = lo - $urandom_range(1, lo - 1);
            default: ;
        endcase
        write_config(spt_pkg::AMP_W'(thr), spt_pkg::BIN_W'(lo), spt_pkg::BIN_W'(hi));
    endtask

    task automatic send_random_frame();
        int len;
        int pos;
        int base;
        bit noisy;
        bit tied;
        logic [spt_pkg::AMP_W-1:0] a;
        len   = $urandom_range(1, 24);
        noisy = ($urandom_range(0, 7) == 0);
        tied  = $urandom_range(0, 1);
        base  = int'(thr_amp) + $urandom_range(0, 64);
        if (base > 24'hFF_FFFF) base = 24'hFF_FFFF;
        pos = ($urandom_range(0, 4) == 0) ? int'(hi_bin) - len + 2
                                          : int'(lo_bin) - $urandom_range(0, 3);
        for (int i = 0; i < len; i++) begin
            if (noisy) pos = $urandom_range(0, 2047);
            else if (i > 0) pos += $urandom_range(1, 2);
            if (pos < 0) pos = 0;
            if (pos > 2047) pos = 2047;
            if (tied) begin
                a = spt_pkg::AMP_W'(base) - spt_pkg::AMP_W'($urandom_range(0, 3));
            end else begin
                a = spt_pkg::AMP_W'($urandom_range(0, 24'hFF_FFFF));
            end
            send_bin(spt_pkg::BIN_W'(pos), a, i == len - 1);
        end
    endtask

    task automatic test_random_frames();
        int frame;
        frame = 0;
        while (items_sent < RANDOM_ITEMS + 22) begin
            gaps_on = !(frame >= 8 && frame < 14);
            if (frame % 3 == 0) begin
                wait_list_out();
                random_config();
            end
            send_random_frame();
            frame++;
        end
        gaps_on = 1'b1;
        wait_list_out();
    endtask

    initial begin
        thr_amp = '0;
        lo_bin  = 11'd1;
        hi_bin  = 11'd2047;
        clear_peaks();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_frame();
        test_ties_at_range_end();
        test_list_overflow();
        test_config_extremes();
        test_random_frames();
        if (fail_cnt == 0) begin
            $display("** spectral_peak_top_k_unit: PASSED **");
        end else begin
            $display("** spectral_peak_top_k_unit: FAILED **");
        end
        $finish;
    end

endmodule
